[hw/rtl/cfsf_pkg.sv]
// Package for the causal fire smear filter.
// Holds the field widths, configuration register indexes and the result record.
// No dependencies; cfsf_outq and the top level import it.
`default_nettype none

package cfsf_pkg;

    // Field and register widths.
    localparam int HEAT_W     = 8;
    localparam int FW_BITS    = 11;
    localparam int FH_BITS    = 12;
    localparam int CO_BITS    = 7;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    // Eight 8-bit neighbors need 11 bits of sum.
    localparam int SUM_W      = 11;
    localparam int HEAT_SHIFT = 3;

    // Result queue: depth, and the free space kept for requests in flight.
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_SLACK = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL_OFF     = 2'd2;

    // Register values after reset.
    localparam logic [FW_BITS-1:0] FW_RESET = 11'd1024;
    localparam logic [FH_BITS-1:0] FH_RESET = 12'd256;
    localparam logic [CO_BITS-1:0] CO_RESET = 7'd16;

    // One filtered pixel with its markers.
    typedef struct packed {
        logic [HEAT_W-1:0] heat;
        logic              last_of_run;
        logic              row_done;
        logic              frame_done;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/cfsf_ram.sv]
// Generic single-clock RAM for the fire smear filter: one write port, one read port.
// Read data is registered and returns the old contents on a same-address write.
// No dependencies.
`default_nettype none

module cfsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read in one process so a same-address read sees the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/cfsf_outq.sv]
// Result queue of the fire smear filter: a small register FIFO in front of the output.
// It reports whether enough room is left to take one more input request.
// Depends on cfsf_pkg.
`default_nettype none

module cfsf_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire cfsf_pkg::t_result i_push_data,
    output logic                  o_room,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output cfsf_pkg::t_result     o_data
);

    import cfsf_pkg::*;

    localparam int PW   = $clog2(OUTQ_DEPTH);
    localparam int CNTW = $clog2(OUTQ_DEPTH + 1);

    t_result          r_mem [OUTQ_DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CNTW-1:0]  r_count;
    logic [CNTW-1:0]  n_count;
    logic             pop;

    // Handshake on the output side.
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign pop     = o_valid && i_ready;

    // Room for every result that the requests in flight can still produce.
    assign o_room  = (r_count <= CNTW'(OUTQ_DEPTH - OUTQ_SLACK));

    assign n_count = r_count + CNTW'(i_push) - CNTW'(pop);

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            r_count <= n_count;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/causal_fire_smear_filter.sv]
// Top level of the causal fire smear filter.
// Depends on cfsf_pkg, cfsf_ram (above-row and pending-row stores) and cfsf_outq.
//
// Usage:
// The heat map enters in raster order on i_heat_in, one pixel per request, under
// i_in_valid / o_in_ready. Filtered pixels leave one row behind on o_heat_out with
// their markers under o_out_valid / i_out_ready. After the last row of a frame the
// sender supplies one flush row; its values are ignored and it releases the last
// filtered row, whose final pixel carries o_frame_done.
// Throughput is one input pixel per clock while o_in_ready is high. A result is
// computed from the registered request and queued. The closing pixel of a row
// follows in the cycle after and is computed by the same filter adder while the
// next row's first pixel, which has no result, is taken in. The rate is set by
// that adder and the single above-row write port: one filtered pixel per cycle.
// Results queue in an eight-entry FIFO. When the receiver stalls, input requests
// keep being accepted until the FIFO holds more than four results; o_in_ready then
// drops until it drains.
// Reset (synchronous, active low) restores the registers and starts a clearing
// pass over every address of the above-row memory, during which o_in_ready is
// low. Configuration writes are taken at any time and must only be issued while
// the block is idle.
`default_nettype none

module causal_fire_smear_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cfsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cfsf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [cfsf_pkg::HEAT_W-1:0]     i_heat_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [cfsf_pkg::HEAT_W-1:0]     o_heat_out,
    output logic                                 o_last_of_run,
    output logic                                 o_row_done,
    output logic                                 o_frame_done
);

    import cfsf_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > FW_BITS) ? WW : FW_BITS;

    // Configuration registers.
    logic [FW_BITS-1:0] r_frame_width;
    logic [FH_BITS-1:0] r_frame_height;
    logic [CO_BITS-1:0] r_cool_off;

    // Raster position and the last two inputs.
    logic [CW-1:0]      r_col;
    logic [FH_BITS-1:0] r_row;
    logic [HEAT_W-1:0]  r_b1;
    logic [HEAT_W-1:0]  r_b2;
    logic [CW-1:0]      n_col;
    logic [FH_BITS-1:0] n_row;

    // Geometry of the current request.
    logic [CMPW-1:0]    fw_ext;
    logic [CMPW-1:0]    w_sel;
    logic [CW-1:0]      last_col;
    logic [CW-1:0]      c_eff;
    logic [FH_BITS-1:0] h_eff;
    logic [FH_BITS-1:0] r_eff;
    logic               flush;
    logic               accept;
    logic [HEAT_W-1:0]  heat_v;
    logic               item_op;
    logic               item_last;
    logic               item_first;
    logic               item_x0;

    // Filter stage registers.
    logic               r_s1_valid;
    logic               r_s1_op;
    logic               r_s1_last;
    logic               r_s1_first;
    logic               r_s1_flush;
    logic               r_s1_x0;
    logic [CW-1:0]      r_s1_x;
    logic [HEAT_W-1:0]  r_s1_v;
    logic [HEAT_W-1:0]  r_s1_b1;
    logic [HEAT_W-1:0]  r_s1_b2;
    logic               r_s1_fwd;
    logic [HEAT_W-1:0]  r_fwd_data;

    // Closing pixel of a row.
    logic               r_s2_valid;
    logic               r_s2_first;
    logic               r_s2_flush;
    logic [HEAT_W-1:0]  r_s2_bl;
    logic [HEAT_W-1:0]  r_s2_bc;
    logic [CW-1:0]      r_s2_x;

    // Above-row window and last filtered pixel.
    logic [HEAT_W-1:0]  r_above0;
    logic [HEAT_W-1:0]  r_above1;
    logic [HEAT_W-1:0]  r_left;

    // Clearing pass after reset.
    logic               r_clr_busy;
    logic [CW-1:0]      r_clr_addr;

    // Memory ports.
    logic               f_we;
    logic [CW-1:0]      f_waddr;
    logic [HEAT_W-1:0]  f_wdata;
    logic [HEAT_W-1:0]  f_rdata;
    logic [HEAT_W-1:0]  p_rdata;
    logic [HEAT_W-1:0]  f_eff;
    logic               fwd_hit;

    // Filter unit.
    logic               s1_fire;
    logic               s2_fire;
    logic               op_fire;
    logic [HEAT_W-1:0]  op_a0;
    logic [HEAT_W-1:0]  op_a1;
    logic [HEAT_W-1:0]  op_a2;
    logic [HEAT_W-1:0]  op_left;
    logic [HEAT_W-1:0]  op_right;
    logic [HEAT_W-1:0]  op_bl;
    logic [HEAT_W-1:0]  op_bc;
    logic [HEAT_W-1:0]  op_br;
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   cool_ext;
    logic [HEAT_W-1:0]  res;

    // Result queue.
    t_result            push_data;
    t_result            q_data;
    logic               q_room;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
            r_cool_off     <= CO_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_BITS-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_BITS-1:0];
                CFG_COOL_OFF:     r_cool_off     <= i_cfg_data[CO_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Width clamped to 2..MAX_WIDTH, height of zero taken as one.
    always_comb begin
        fw_ext = CMPW'(r_frame_width);
        if (fw_ext < CMPW'(2)) begin
            w_sel = CMPW'(2);
        end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
            w_sel = CMPW'(MAX_WIDTH);
        end else begin
            w_sel = fw_ext;
        end
        last_col = CW'(w_sel - CMPW'(1));
        c_eff    = (r_col > last_col) ? last_col : r_col;
        h_eff    = (r_frame_height == '0) ? FH_BITS'(1) : r_frame_height;
        flush    = (r_row >= h_eff);
        r_eff    = flush ? h_eff : r_row;
    end

    assign o_in_ready = !r_clr_busy && q_room;
    assign accept     = i_in_valid && o_in_ready;
    assign heat_v     = flush ? '0 : i_heat_in;

    // What the request causes: one pixel left of it, and the row's last at the end.
    assign item_op    = (r_eff != '0) && (c_eff != '0);
    assign item_last  = (r_eff != '0) && (c_eff == last_col);
    assign item_first = (r_eff == FH_BITS'(1));
    assign item_x0    = (c_eff == CW'(1));

    // Next raster position.
    always_comb begin
        if (c_eff == last_col) begin
            n_col = '0;
            n_row = flush ? '0 : r_eff + FH_BITS'(1);
        end else begin
            n_col = c_eff + CW'(1);
            n_row = r_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_b1  <= '0;
            r_b2  <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_b2  <= r_b1;
            r_b1  <= heat_v;
        end
    end

    // Pending row: unfiltered pixels of the row above the incoming one.
    cfsf_ram #(
        .WIDTH (HEAT_W),
        .DEPTH (MAX_WIDTH)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (c_eff),
        .i_wdata (heat_v),
        .i_raddr (c_eff),
        .o_rdata (p_rdata)
    );

    // Above row: filtered pixels, overwritten in place as the filter advances.
    cfsf_ram #(
        .WIDTH (HEAT_W),
        .DEPTH (MAX_WIDTH)
    ) u_above_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (c_eff),
        .o_rdata (f_rdata)
    );

    assign s1_fire = r_s1_valid && r_s1_op;
    assign s2_fire = r_s2_valid;
    assign op_fire = s1_fire || s2_fire;

    // Above-row write port: clearing pass, then the filtered pixel of this cycle.
    always_comb begin
        f_we    = 1'b0;
        f_waddr = r_s1_x;
        f_wdata = res;
        if (r_clr_busy) begin
            f_we    = 1'b1;
            f_waddr = r_clr_addr;
            f_wdata = '0;
        end else if (s1_fire) begin
            f_we    = 1'b1;
            f_waddr = r_s1_x;
        end else if (s2_fire) begin
            f_we    = 1'b1;
            f_waddr = r_s2_x;
        end
    end

    // A write landing on the address being read is forwarded to the next cycle.
    assign fwd_hit = f_we && (f_waddr == c_eff);
    assign f_eff   = r_s1_fwd ? r_fwd_data : f_rdata;

    // Stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid && r_s1_last;
        end
    end

    // Stage payload, captured with the request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op    <= item_op;
            r_s1_last  <= item_last;
            r_s1_first <= item_first;
            r_s1_flush <= flush;
            r_s1_x0    <= item_x0;
            r_s1_x     <= c_eff - CW'(1);
            r_s1_v     <= heat_v;
            r_s1_b1    <= r_b1;
            r_s1_b2    <= r_b2;
            r_s1_fwd   <= fwd_hit;
            r_fwd_data <= f_wdata;
        end
        if (r_s1_valid) begin
            r_s2_first <= r_s1_first;
            r_s2_flush <= r_s1_flush;
            r_s2_bl    <= r_s1_b1;
            r_s2_bc    <= r_s1_v;
            r_s2_x     <= r_s1_x + CW'(1);
        end
    end

    // Above-row window slides with each request; left follows each filtered pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above0 <= '0;
            r_above1 <= '0;
            r_left   <= '0;
        end else begin
            if (r_s1_valid) begin
                r_above0 <= r_above1;
                r_above1 <= f_eff;
            end
            if (op_fire) begin
                r_left <= res;
            end
        end
    end

    // Operand selection: the row's closing pixel has no upper-right, right or lower-right neighbor.
    always_comb begin
        if (s1_fire) begin
            op_a0    = (r_s1_first || r_s1_x0) ? '0 : r_above0;
            op_a1    = r_s1_first ? '0 : r_above1;
            op_a2    = r_s1_first ? '0 : f_eff;
            op_left  = r_s1_x0 ? '0 : r_left;
            op_right = p_rdata;
            op_bl    = r_s1_x0 ? '0 : r_s1_b2;
            op_bc    = r_s1_b1;
            op_br    = r_s1_v;
        end else begin
            op_a0    = r_s2_first ? '0 : r_above0;
            op_a1    = r_s2_first ? '0 : r_above1;
            op_a2    = '0;
            op_left  = r_left;
            op_right = '0;
            op_bl    = r_s2_bl;
            op_bc    = r_s2_bc;
            op_br    = '0;
        end
    end

    // Neighbor sum, cooling and scaling.
    always_comb begin
        sum = SUM_W'(op_a0) + SUM_W'(op_a1) + SUM_W'(op_a2) + SUM_W'(op_left)
            + SUM_W'(op_right) + SUM_W'(op_bl) + SUM_W'(op_bc) + SUM_W'(op_br);
        cool_ext = SUM_W'(r_cool_off);
        if (sum >= cool_ext) begin
            res = HEAT_W'((sum - cool_ext) >> HEAT_SHIFT);
        end else begin
            res = '0;
        end
    end

    // Clearing pass over the above-row memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + CW'(1);
        end
    end

    // Result record.
    always_comb begin
        push_data.heat        = res;
        push_data.last_of_run = s1_fire ? !r_s1_last : 1'b1;
        push_data.row_done    = !s1_fire;
        push_data.frame_done  = !s1_fire && r_s2_flush;
    end

    cfsf_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (op_fire),
        .i_push_data (push_data),
        .o_room      (q_room),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (q_data)
    );

    assign o_heat_out    = q_data.heat;
    assign o_last_of_run = q_data.last_of_run;
    assign o_row_done    = q_data.row_done;
    assign o_frame_done  = q_data.frame_done;

endmodule

`default_nettype wire

[hw/rtl/cfsf_checker.sv]
// Port-level checker for the causal fire smear filter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module cfsf_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic o_last_of_run,
    input wire logic o_row_done,
    input wire logic o_frame_done
);

    // The clearing pass holds off input right after reset.
    a_ready_low_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("input ready right after reset");

    // No result is shown right after reset.
    a_no_result_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // The frame's last pixel closes its row and its run.
    a_frame_closes_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> (o_row_done && o_last_of_run))
        else $error("frame end without row end");

    // A row's last pixel is always the last result of its request.
    a_row_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_row_done) |-> o_last_of_run)
        else $error("row end not last of run");

endmodule

bind causal_fire_smear_filter cfsf_checker u_cfsf_checker (.*);

`default_nettype wire
